>>> rtl/core/multi_task_heartbeat_watchdog_top_macros.svh
// Assertion macros for the heartbeat watchdog.
// Included by the top level; no other dependencies.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_TOP_MACROS_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MTWD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("watchdog assertion failed");
`define MTWD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("watchdog assertion failed");
`else
`define MTWD_ASSERT(lbl, clk, rst, prop)
`define MTWD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/mtwd_pkg.sv
// Shared types and constants for the heartbeat watchdog.
// No dependencies.
`default_nettype none
package mtwd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CIV_W  = 16;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd5000;
  localparam logic [CNT_W-1:0]  THRESHOLD_RST = 8'd3;
  localparam logic [CIV_W-1:0]  INTERVAL_RST  = 16'd1000;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_BEAT  = 2'd3
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_INTERVAL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] task_id;
  } item_t;

  typedef struct packed {
    logic              reset_request;
    logic [MASK_W-1:0] timeout_mask;
    logic [MASK_W-1:0] alive_mask;
  } result_t;

  // Per-task update from the sequencer
  typedef struct packed {
    logic start;
    logic stop;
    logic beat;
  } task_cmd_t;

  // One task entry as read by the walk
  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] last_beat;
    logic [CNT_W-1:0]  count;
  } task_rd_t;

  // Shared evaluation unit output
  typedef struct packed {
    logic             alive;
    logic             timed_out;
    logic [CNT_W-1:0] count_next;
    logic             over;
  } eval_t;

endpackage
`default_nettype wire

>>> rtl/core/mtwd_eval.sv
// Shared elapsed-time compare and count saturation unit.
// Depends on mtwd_pkg.
`default_nettype none
module mtwd_eval
  import mtwd_pkg::*;
(
  input  task_rd_t          entry,
  input  logic [TIME_W-1:0] now_ticks,
  input  logic [TIME_W-1:0] timeout_ticks,
  input  logic [CNT_W-1:0]  error_threshold,
  output eval_t             res
);

  logic [TIME_W-1:0] elapsed;
  logic              expired;

  // Modulo-2^32 elapsed time
  assign elapsed = now_ticks - entry.last_beat;
  assign expired = (elapsed >= timeout_ticks);

  always_comb begin
    res.alive      = !entry.active || !expired;
    res.timed_out  = entry.active && expired;
    res.count_next = (entry.count == CNT_MAX) ? CNT_MAX : entry.count + CNT_W'(1);
    res.over       = res.timed_out && (res.count_next >= error_threshold);
  end

endmodule
`default_nettype wire

>>> rtl/core/mtwd_task_file.sv
// Per-task state: active bit, last heartbeat time, timeout count.
// Depends on mtwd_pkg.
`default_nettype none
module mtwd_task_file
  import mtwd_pkg::*;
#(
  parameter int unsigned TASKS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  task_cmd_t         cmd,
  input  logic [IDX_W-1:0]  cmd_idx,
  input  logic [TIME_W-1:0] now_ticks,
  input  logic              cnt_we,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [CNT_W-1:0]  cnt_val,
  output task_rd_t          rd
);

  logic              active    [TASKS];
  logic [TIME_W-1:0] last_beat [TASKS];
  logic [CNT_W-1:0]  count     [TASKS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASKS; i++) begin
        active[i]    <= 1'b0;
        last_beat[i] <= '0;
        count[i]     <= '0;
      end
    end else begin
      if (cmd.start) begin
        active[cmd_idx]    <= 1'b1;
        last_beat[cmd_idx] <= now_ticks;
        count[cmd_idx]     <= '0;
      end else if (cmd.stop) begin
        active[cmd_idx] <= 1'b0;
      end else if (cmd.beat && active[cmd_idx]) begin
        last_beat[cmd_idx] <= now_ticks;
        count[cmd_idx]     <= '0;
      end
      if (cnt_we) begin
        count[rd_idx] <= cnt_val;
      end
    end
  end

  always_comb begin
    rd.active    = active[rd_idx];
    rd.last_beat = last_beat[rd_idx];
    rd.count     = count[rd_idx];
  end

endmodule
`default_nettype wire

>>> rtl/core/multi_task_heartbeat_watchdog_top.sv
// A request is taken in S_IDLE, then the walk (S_WALK) visits every task and
// S_EMIT loads the result register, waiting while that register is still full.
// A new request is taken only back in S_IDLE, after the walk of the task file
// through the single shared compare unit, one task a cycle, and the result load.
// Reset (rst, synchronous): tick and interval counters clear, all tasks go
// inactive, config registers return to 5000 / 3 / 1000, no result pending.
`default_nettype none
`include "multi_task_heartbeat_watchdog_top_macros.svh"
module multi_task_heartbeat_watchdog_top
  import mtwd_pkg::*;
#(
  parameter int unsigned TASKS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CMP_W = IDX_W + 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);
  // Mask bits for task slots that do not exist read as alive
  localparam logic [MASK_W-1:0] ALIVE_PAD =
    (TASKS >= MASK_W) ? '0 : MASK_W'(~((17'(1) << TASKS) - 17'(1)));

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] timeout_ticks;
  logic [CNT_W-1:0]  error_threshold;
  logic [CIV_W-1:0]  check_interval_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks        <= TIMEOUT_RST;
      error_threshold      <= THRESHOLD_RST;
      check_interval_ticks <= INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_ticks        <= cfg_data;
        REG_THRESHOLD: error_threshold      <= cfg_data[CNT_W-1:0];
        REG_INTERVAL:  check_interval_ticks <= cfg_data[CIV_W-1:0];
        default: ;  // unmapped index is ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t            state;
  logic [TIME_W-1:0] now_ticks;
  logic [CIV_W-1:0]  interval_count;
  logic              check;       // this request runs a check
  logic [IDX_W-1:0]  walk_idx;
  logic              req_acc;
  logic [MASK_W-1:0] tmask_acc;
  logic [MASK_W-1:0] amask_acc;

  logic              item_acc;
  logic              id_ok;
  logic [CIV_W-1:0]  interval_inc;
  logic              interval_hit;
  logic              emit_go;
  logic              in_mask;
  logic [2:0]        mask_bit;

  task_cmd_t         cmd;
  task_rd_t          entry;
  eval_t             ev;
  logic              cnt_we;

  assign item_ready   = (state == S_IDLE);
  assign item_acc     = item_valid && item_ready;
  assign id_ok        = (CMP_W'(item.task_id) < CMP_W'(TASKS));
  assign interval_inc = interval_count + CIV_W'(1);
  assign interval_hit = (interval_inc >= check_interval_ticks);
  // Result register is free, or its current request leaves this cycle
  assign emit_go      = !result_valid || result_ready;
  // Tasks past the eighth are checked but have no mask bit
  assign in_mask      = (CMP_W'(walk_idx) < CMP_W'(MASK_W));
  assign mask_bit     = 3'(walk_idx);

  // Start/stop/heartbeat land in the task file at the accept edge
  always_comb begin
    cmd.start = item_acc && id_ok && (item.kind == KIND_START);
    cmd.stop  = item_acc && id_ok && (item.kind == KIND_STOP);
    cmd.beat  = item_acc && id_ok && (item.kind == KIND_BEAT);
  end

  assign cnt_we = (state == S_WALK) && check && ev.timed_out;

  mtwd_task_file #(
    .TASKS (TASKS),
    .IDX_W (IDX_W)
  ) u_task_file (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_idx   (IDX_W'(item.task_id)),
    .now_ticks (now_ticks),
    .cnt_we    (cnt_we),
    .rd_idx    (walk_idx),
    .cnt_val   (ev.count_next),
    .rd        (entry)
  );

  // One subtract/compare unit shared by every task of the walk
  mtwd_eval u_eval (
    .entry           (entry),
    .now_ticks       (now_ticks),
    .timeout_ticks   (timeout_ticks),
    .error_threshold (error_threshold),
    .res             (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      now_ticks      <= '0;
      interval_count <= '0;
      check          <= 1'b0;
      walk_idx       <= '0;
      req_acc        <= 1'b0;
      tmask_acc      <= '0;
      amask_acc      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            walk_idx  <= '0;
            req_acc   <= 1'b0;
            tmask_acc <= '0;
            amask_acc <= ALIVE_PAD;
            check     <= 1'b0;
            if (item.kind == KIND_TICK) begin
              now_ticks <= now_ticks + TIME_W'(1);
              if (interval_hit) begin
                interval_count <= '0;
                check          <= 1'b1;
              end else begin
                interval_count <= interval_inc;
              end
            end
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (in_mask && ev.alive) begin
            amask_acc[mask_bit] <= 1'b1;
          end
          if (check && ev.timed_out) begin
            if (in_mask) begin
              tmask_acc[mask_bit] <= 1'b1;
            end
            if (ev.over) begin
              req_acc <= 1'b1;
            end
          end
          if (walk_idx == LAST_IDX) begin
            state <= S_EMIT;
          end else begin
            walk_idx <= walk_idx + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished result while the next request is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      result.reset_request <= req_acc;
      result.timeout_mask  <= tmask_acc;
      result.alive_mask    <= amask_acc;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MTWD_ASSERT(a_accept_walks, clk, rst, item_acc |=> (state == S_WALK && walk_idx == '0))
  `MTWD_ASSERT(a_walk_ends, clk, rst,
    (state == S_WALK && walk_idx == LAST_IDX) |=> (state == S_EMIT))
  `MTWD_ASSERT(a_no_phantom_timeout, clk, rst,
    result_valid |-> ((result.timeout_mask & ALIVE_PAD) == '0))
  `MTWD_ASSERT(a_req_has_timeout, clk, rst,
    (result_valid && result.reset_request) |-> (TASKS > MASK_W || result.timeout_mask != '0))
  `MTWD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !result_valid))

endmodule
`default_nettype wire
